// ===== hw/rtl/pwvc_pkg.sv =====
// Shared types and constants for the pulse-width voice command sender.
// No dependencies; pwvc_seq and the top level import this package.
package pwvc_pkg;

   // Tick counts and register port widths
   localparam int TICK_W    = 20;
   localparam int CSR_IDX_W = 3;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_LEAD_HIGH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LEAD_LOW  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LONG      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SHORT     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_GAP       = 3'd4;

   // Register values after reset
   localparam logic [TICK_W-1:0] RST_LEAD_HIGH = 20'd1000;
   localparam logic [TICK_W-1:0] RST_LEAD_LOW  = 20'd3200;
   localparam logic [TICK_W-1:0] RST_LONG      = 20'd1200;
   localparam logic [TICK_W-1:0] RST_SHORT     = 20'd400;
   localparam logic [TICK_W-1:0] RST_GAP       = 20'd300000;

   // Phase lengths handed to the sequencer
   typedef struct packed {
      logic [TICK_W-1:0] lead_high;
      logic [TICK_W-1:0] lead_low;
      logic [TICK_W-1:0] long_len;
      logic [TICK_W-1:0] short_len;
      logic [TICK_W-1:0] gap;
   } cfg_type;

   // Result of one item
   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic rejected;
   } rsp_type;

endpackage

// ===== hw/rtl/pwvc_if.sv =====
// Handshake channels of the pulse-width voice command sender.
// Standalone; carries valid, ready and the item payload.
interface pwvc_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] track_number;

   modport source (output valid, output cmd, output track_number, input ready);
   modport sink   (input valid, input cmd, input track_number, output ready);
endinterface

interface pwvc_rsp_if;
   logic valid;
   logic ready;
   logic line_level;
   logic busy_res;
   logic rejected;

   modport source (output valid, output line_level, output busy_res, output rejected,
                   input ready);
   modport sink   (input valid, input line_level, input busy_res, input rejected,
                   output ready);
endinterface

// ===== hw/rtl/pwvc_seq.sv =====
// Phase sequencer: timer, bit and byte counters, line level.
// Depends on pwvc_pkg for the configuration and result structs.
module pwvc_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_valid,
   input  logic              step_cmd,
   input  logic [7:0]        step_track,
   input  pwvc_pkg::cfg_type cfg,
   output pwvc_pkg::rsp_type res
);
   import pwvc_pkg::*;

   localparam logic [7:0] BYTE_OPEN  = 8'h0a;
   localparam logic [7:0] BYTE_CLOSE = 8'h0b;

   typedef enum logic [5:0] {
      PH_IDLE    = 6'b000001,
      PH_LEAD_HI = 6'b000010,
      PH_LEAD_LO = 6'b000100,
      PH_BIT_HI  = 6'b001000,
      PH_BIT_LO  = 6'b010000,
      PH_GAP     = 6'b100000
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [TICK_W-1:0] timer_ff, timer_in;
   logic [2:0]        bit_ff, bit_in;
   logic [1:0]        byte_ff, byte_in;
   logic [7:0]        shift_ff, shift_in;
   logic [4:0]        tens_ff, tens_in;
   logic [3:0]        units_ff, units_in;
   logic              line_ff, line_in;
   logic              rej;

   logic [15:0]       tens_prod;
   logic [4:0]        track_tens;
   logic [7:0]        tens_x10;
   logic [7:0]        track_units;
   logic [1:0]        next_byte;
   logic [7:0]        next_shift;

   // Split the track into digits: x*205>>11 is x/10 for x below 1029
   assign tens_prod   = {8'd0, step_track} * 16'd205;
   assign track_tens  = tens_prod[15:11];
   assign tens_x10    = {3'd0, track_tens} * 8'd10;
   assign track_units = step_track - tens_x10;

   // Pick the byte that follows the current one
   assign next_byte = byte_ff + 2'd1;
   always_comb begin
      case (next_byte)
         2'd1:    next_shift = {3'd0, tens_ff};
         2'd2:    next_shift = {4'd0, units_ff};
         2'd3:    next_shift = BYTE_CLOSE;
         default: next_shift = BYTE_OPEN;
      endcase
   end

   // Start a sequence or step the timer and phase on each accepted item
   always_comb begin
      phase_in = phase_ff;
      timer_in = timer_ff;
      bit_in   = bit_ff;
      byte_in  = byte_ff;
      shift_in = shift_ff;
      tens_in  = tens_ff;
      units_in = units_ff;
      line_in  = line_ff;
      rej      = 1'b0;
      if (step_valid) begin
         if (step_cmd) begin
            if (phase_ff != PH_IDLE) begin
               rej = 1'b1;
            end else begin
               tens_in  = track_tens;
               units_in = track_units[3:0];
               byte_in  = 2'd0;
               bit_in   = 3'd0;
               shift_in = BYTE_OPEN;
               phase_in = PH_LEAD_HI;
               line_in  = 1'b1;
               timer_in = cfg.lead_high;
            end
         end else if (phase_ff != PH_IDLE) begin
            if (timer_ff <= 20'd1) begin
               unique case (phase_ff)
                  PH_LEAD_HI: begin
                     phase_in = PH_LEAD_LO;
                     line_in  = 1'b0;
                     timer_in = cfg.lead_low;
                  end
                  PH_LEAD_LO: begin
                     phase_in = PH_BIT_HI;
                     line_in  = 1'b1;
                     timer_in = shift_ff[0] ? cfg.long_len : cfg.short_len;
                  end
                  PH_BIT_HI: begin
                     phase_in = PH_BIT_LO;
                     line_in  = 1'b0;
                     timer_in = shift_ff[0] ? cfg.short_len : cfg.long_len;
                  end
                  PH_BIT_LO: begin
                     shift_in = {1'b0, shift_ff[7:1]};
                     bit_in   = bit_ff + 3'd1;
                     line_in  = 1'b1;
                     if (bit_ff == 3'd7) begin
                        phase_in = PH_GAP;
                        timer_in = cfg.gap;
                     end else begin
                        phase_in = PH_BIT_HI;
                        timer_in = shift_ff[1] ? cfg.long_len : cfg.short_len;
                     end
                  end
                  PH_GAP: begin
                     bit_in  = 3'd0;
                     line_in = 1'b1;
                     if (byte_ff == 2'd3) begin
                        byte_in  = 2'd0;
                        phase_in = PH_IDLE;
                        timer_in = '0;
                     end else begin
                        byte_in  = next_byte;
                        shift_in = next_shift;
                        phase_in = PH_LEAD_HI;
                        timer_in = cfg.lead_high;
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                     line_in  = 1'b1;
                     timer_in = '0;
                  end
               endcase
            end else begin
               timer_in = timer_ff - 20'd1;
            end
         end
      end
   end

   // Hold sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         timer_ff <= '0;
         bit_ff   <= '0;
         byte_ff  <= '0;
         shift_ff <= '0;
         tens_ff  <= '0;
         units_ff <= '0;
         line_ff  <= 1'b1;
      end else begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         bit_ff   <= bit_in;
         byte_ff  <= byte_in;
         shift_ff <= shift_in;
         tens_ff  <= tens_in;
         units_ff <= units_in;
         line_ff  <= line_in;
      end
   end

   // Result of the item being taken
   assign res.line_level = line_in;
   assign res.busy_res   = (phase_in != PH_IDLE);
   assign res.rejected   = rej;

`ifndef ASSERT_OFF
   // Idle always leaves the line high
   a_idle_high: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> line_ff)
      else $error("line low while idle");

   // The bit low phase only follows a high bit half or itself
   a_low_entry: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BIT_LO) |-> ($past(phase_ff) == PH_BIT_HI || $past(phase_ff) == PH_BIT_LO))
      else $error("bit low phase entered out of order");

   // Digits of a track never exceed their ranges
   a_digits: assert property (@(posedge clock) disable iff (reset)
      (tens_ff <= 5'd25) && (units_ff <= 4'd9))
      else $error("track digit out of range");
`endif

endmodule

// ===== hw/rtl/pulse_width_voice_command_sender_unit.sv =====
// Top level of the pulse-width voice command sender.
// Depends on pwvc_pkg, pwvc_if (channels) and pwvc_seq (phase sequencer).
//
//  channel  dir  payload                                handshake
//  req_if   in   cmd, track_number                      valid / ready
//  rsp_if   out  line_level, busy_res, rejected         valid / ready
//  csr_*    in   csr_index, csr_wdata                   csr_wr_en, no back-pressure
//
// The sequencer state and the output register both update at the edge that
// accepts an item; one item per cycle is sustained while results are taken.
// Reset is synchronous and returns the sequencer to idle with the line high and
// the phase lengths to their defaults; no item is taken while reset is high.
// A stalled result blocks a new item only while the output register is full
// and not being taken.
module pulse_width_voice_command_sender_unit (
   input  logic                             clock,
   input  logic                             reset,
   pwvc_req_if.sink                         req_if,
   pwvc_rsp_if.source                       rsp_if,
   input  logic                             csr_wr_en,
   input  logic [pwvc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pwvc_pkg::TICK_W-1:0]      csr_wdata
);
   import pwvc_pkg::*;

   cfg_type cfg_ff;
   rsp_type res;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   logic    req_accept;

   // Write the phase length registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lead_high <= RST_LEAD_HIGH;
         cfg_ff.lead_low  <= RST_LEAD_LOW;
         cfg_ff.long_len  <= RST_LONG;
         cfg_ff.short_len <= RST_SHORT;
         cfg_ff.gap       <= RST_GAP;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_LEAD_HIGH: cfg_ff.lead_high <= csr_wdata;
            REG_LEAD_LOW:  cfg_ff.lead_low  <= csr_wdata;
            REG_LONG:      cfg_ff.long_len  <= csr_wdata;
            REG_SHORT:     cfg_ff.short_len <= csr_wdata;
            REG_GAP:       cfg_ff.gap       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Take an item whenever the output register is free or draining
   assign req_if.ready = !reset && (!rsp_valid_ff || rsp_if.ready);
   assign req_accept   = req_if.valid && req_if.ready;

   pwvc_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .step_valid (req_accept),
      .step_cmd   (req_if.cmd),
      .step_track (req_if.track_number),
      .cfg        (cfg_ff),
      .res        (res)
   );

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= res;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.line_level = rsp_ff.line_level;
   assign rsp_if.busy_res   = rsp_ff.busy_res;
   assign rsp_if.rejected   = rsp_ff.rejected;

`ifndef ASSERT_OFF
   // A tick item never yields a rejection
   a_tick_no_rej: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !req_if.cmd) |=> !rsp_if.rejected)
      else $error("tick item flagged as rejected");

   // A rejected start leaves the sequence running
   a_rej_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.rejected) |-> rsp_if.busy_res)
      else $error("rejection reported while not busy");

   // Never take an item over a result still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_if.ready) |-> !req_accept)
      else $error("pending result overwritten");

   // Not busy means the line rests high
   a_rest_high: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.busy_res) |-> rsp_if.line_level)
      else $error("line low while not busy");
`endif

endmodule
